FILE: rtl/ifsd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifsd_pkg
// Shared types, codes and helpers for the sensor frame sync decoder.
// ----------------------------------------------------------------------------
package ifsd_pkg;

   localparam int FRAME_BYTES_DEF = 11;
   localparam int QUEUE_DEPTH     = 2;
   localparam int AXIS_W          = 27;
   localparam int SCALE_W         = 11;

   localparam logic [7:0] HDR_BYTE   = 8'h55;
   localparam logic [7:0] TYPE_FIRST = 8'h51;
   localparam logic [7:0] TYPE_LAST  = 8'h53;

   localparam logic [1:0] KIND_ACCEL = 2'd0;
   localparam logic [1:0] KIND_GYRO  = 2'd1;
   localparam logic [1:0] KIND_ANGLE = 2'd2;

   localparam logic [SCALE_W-1:0] SCALE_ACCEL = 11'd16;
   localparam logic [SCALE_W-1:0] SCALE_GYRO  = 11'd16;
   localparam logic [SCALE_W-1:0] SCALE_ANGLE = 11'd2000;

   typedef enum logic [1:0] {
      PH_HUNT,
      PH_TYPE,
      PH_BODY
   } phase_type;

   // one complete frame, raw axes as received
   typedef struct packed {
      logic [1:0]         kind;
      logic signed [15:0] raw_x;
      logic signed [15:0] raw_y;
      logic signed [15:0] raw_z;
   } frame_type;

   function automatic logic [SCALE_W-1:0] kind_scale(input logic [1:0] kind);
      logic [SCALE_W-1:0] s;
      unique case (kind)
         KIND_ACCEL: s = SCALE_ACCEL;
         KIND_GYRO:  s = SCALE_GYRO;
         default:    s = SCALE_ANGLE;
      endcase
      return s;
   endfunction

endpackage

FILE: rtl/ifsd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifsd_front
// Header hunt, type check and payload capture; pushes finished frames.
// ----------------------------------------------------------------------------
module ifsd_front #(
   parameter int FRAME_BYTES = ifsd_pkg::FRAME_BYTES_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                byte_valid,
   output logic                byte_ready,
   input  logic [7:0]          byte_data,
   output logic                push,
   output ifsd_pkg::frame_type push_frame,
   input  logic                queue_full
);
   import ifsd_pkg::*;

   localparam int POS_W = $clog2(FRAME_BYTES);
   localparam logic [POS_W-1:0] POS_LAST = POS_W'(FRAME_BYTES - 1);

   phase_type        phase_ff, phase_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [1:0]       kind_ff, kind_in;
   logic [7:0]       payload_ff [6];
   logic [7:0]       cur_bytes [6];
   logic [POS_W-1:0] pos_nxt;
   logic             take;
   logic             type_ok;
   logic             is_last;

   assign byte_ready = !queue_full;
   assign take       = byte_valid && byte_ready;
   assign pos_nxt    = pos_ff + POS_W'(1);
   assign is_last    = (pos_nxt >= POS_LAST);
   assign type_ok    = (byte_data >= TYPE_FIRST) && (byte_data <= TYPE_LAST);

   // next state
   always_comb begin
      phase_in = phase_ff;
      if (take) begin
         unique case (phase_ff)
            PH_TYPE: begin
               if (type_ok) phase_in = PH_BODY;
               else if (byte_data == HDR_BYTE) phase_in = PH_TYPE;
               else phase_in = PH_HUNT;
            end
            PH_BODY: begin
               if (is_last) phase_in = PH_HUNT;
            end
            default: begin
               phase_in = (byte_data == HDR_BYTE) ? PH_TYPE : PH_HUNT;
            end
         endcase
      end
   end

   // outputs and datapath control
   always_comb begin
      pos_in  = pos_ff;
      kind_in = kind_ff;
      push    = 1'b0;
      if (take) begin
         unique case (phase_ff)
            PH_TYPE: begin
               if (type_ok) begin
                  kind_in = byte_data[1:0] - 2'd1;
                  pos_in  = POS_W'(1);
               end else begin
                  pos_in = '0;
               end
            end
            PH_BODY: begin
               pos_in = pos_nxt;
               if (is_last) begin
                  push   = 1'b1;
                  pos_in = '0;
               end
            end
            default: pos_in = '0;
         endcase
      end
   end

   // current byte overrides its slot so the last payload byte may close the frame
   always_comb begin
      for (int i = 0; i < 6; i++) begin
         if ((phase_ff == PH_BODY) && (pos_nxt == POS_W'(i + 2)))
            cur_bytes[i] = byte_data;
         else
            cur_bytes[i] = payload_ff[i];
      end
   end

   assign push_frame.kind  = kind_ff;
   assign push_frame.raw_x = {cur_bytes[1], cur_bytes[0]};
   assign push_frame.raw_y = {cur_bytes[3], cur_bytes[2]};
   assign push_frame.raw_z = {cur_bytes[5], cur_bytes[4]};

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT;
         pos_ff   <= '0;
         kind_ff  <= KIND_ACCEL;
      end else begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
         kind_ff  <= kind_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take && (phase_ff == PH_BODY)) begin
         for (int i = 0; i < 6; i++) begin
            if (pos_nxt == POS_W'(i + 2)) payload_ff[i] <= byte_data;
         end
      end
   end

endmodule

FILE: rtl/ifsd_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifsd_queue
// Short frame queue between the byte front end and the scaling back end.
// ----------------------------------------------------------------------------
module ifsd_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  ifsd_pkg::frame_type push_frame,
   output logic                full,
   output logic                pop_valid,
   input  logic                pop,
   output ifsd_pkg::frame_type pop_frame
);
   import ifsd_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   frame_type        slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   assign full      = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_frame = slot_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && pop_valid;

   always_comb begin
      wr_ptr_in = do_push ? ptr_inc(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = do_pop ? ptr_inc(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) count_in = count_ff + CNT_W'(1);
      else if (do_pop && !do_push) count_in = count_ff - CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) slot_ff[wr_ptr_ff] <= push_frame;
   end

endmodule

FILE: rtl/ifsd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifsd_back
// Scales the three axes by the frame's full scale into the output register.
// ----------------------------------------------------------------------------
module ifsd_back (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       frame_valid,
   output logic                       frame_pop,
   input  ifsd_pkg::frame_type        frame,
   output logic                       out_valid,
   input  logic                       out_ready,
   output logic [1:0]                 out_kind,
   output logic signed [ifsd_pkg::AXIS_W-1:0] out_x,
   output logic signed [ifsd_pkg::AXIS_W-1:0] out_y,
   output logic signed [ifsd_pkg::AXIS_W-1:0] out_z
);
   import ifsd_pkg::*;

   localparam int PROD_W = 16 + SCALE_W + 1;

   logic                     valid_ff, valid_in;
   logic [1:0]               kind_ff;
   logic signed [AXIS_W-1:0] x_ff, y_ff, z_ff;
   logic signed [SCALE_W:0]  scale;
   logic signed [PROD_W-1:0] prod_x, prod_y, prod_z;

   // output register free or being emptied this cycle
   assign frame_pop = frame_valid && (!valid_ff || out_ready);
   assign scale     = $signed({1'b0, kind_scale(frame.kind)});
   assign prod_x    = PROD_W'(frame.raw_x) * PROD_W'(scale);
   assign prod_y    = PROD_W'(frame.raw_y) * PROD_W'(scale);
   assign prod_z    = PROD_W'(frame.raw_z) * PROD_W'(scale);

   always_comb begin
      valid_in = valid_ff;
      if (frame_pop) valid_in = 1'b1;
      else if (out_ready) valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else valid_ff <= valid_in;
   end

   always_ff @(posedge clock) begin
      if (frame_pop) begin
         kind_ff <= frame.kind;
         x_ff    <= prod_x[AXIS_W-1:0];
         y_ff    <= prod_y[AXIS_W-1:0];
         z_ff    <= prod_z[AXIS_W-1:0];
      end
   end

   assign out_valid = valid_ff;
   assign out_kind  = kind_ff;
   assign out_x     = x_ff;
   assign out_y     = y_ff;
   assign out_z     = z_ff;

endmodule

FILE: rtl/imu_frame_sync_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imu_frame_sync_decoder
// Hunts 11-byte sensor frames in a serial byte stream and emits scaled axes.
// ----------------------------------------------------------------------------
//  channel | direction | payload                               | handshake
//  req_    | in        | rx_byte                               | valid/ready
//  rsp_    | out       | frame_kind, axis_x, axis_y, axis_z    | valid/ready
//
//  one byte accepted per cycle while req_ready is high; a frame's result is
//  written to the queue, then multiplied into the output register
//  results leave at up to one per cycle, set by the output register
//  a two-frame queue sits between byte parsing and scaling; req_ready
//  drops only while that queue is full
//  synchronous reset clears sync state, queue and the result valid
// ----------------------------------------------------------------------------
module imu_frame_sync_decoder #(
   parameter int FRAME_BYTES = ifsd_pkg::FRAME_BYTES_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [7:0]                         req_rx_byte,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [1:0]                         rsp_frame_kind,
   output logic signed [ifsd_pkg::AXIS_W-1:0] rsp_axis_x,
   output logic signed [ifsd_pkg::AXIS_W-1:0] rsp_axis_y,
   output logic signed [ifsd_pkg::AXIS_W-1:0] rsp_axis_z
);
   import ifsd_pkg::*;

   logic      push, full, pop_valid, pop;
   frame_type push_frame, pop_frame;

   ifsd_front #(
      .FRAME_BYTES(FRAME_BYTES)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .byte_valid (req_valid),
      .byte_ready (req_ready),
      .byte_data  (req_rx_byte),
      .push       (push),
      .push_frame (push_frame),
      .queue_full (full)
   );

   ifsd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_frame (push_frame),
      .full       (full),
      .pop_valid  (pop_valid),
      .pop        (pop),
      .pop_frame  (pop_frame)
   );

   ifsd_back u_back (
      .clock       (clock),
      .reset       (reset),
      .frame_valid (pop_valid),
      .frame_pop   (pop),
      .frame       (pop_frame),
      .out_valid   (rsp_valid),
      .out_ready   (rsp_ready),
      .out_kind    (rsp_frame_kind),
      .out_x       (rsp_axis_x),
      .out_y       (rsp_axis_y),
      .out_z       (rsp_axis_z)
   );

endmodule

FILE: rtl/ifsd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifsd_checker
// Port-level checks on the frame sync decoder, bound to the top level.
// ----------------------------------------------------------------------------
module ifsd_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_ready,
   input logic [7:0]                         req_rx_byte,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic [1:0]                         rsp_frame_kind,
   input logic signed [ifsd_pkg::AXIS_W-1:0] rsp_axis_x,
   input logic signed [ifsd_pkg::AXIS_W-1:0] rsp_axis_y,
   input logic signed [ifsd_pkg::AXIS_W-1:0] rsp_axis_z
);
   import ifsd_pkg::*;

   // no result straight out of reset
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // offered byte waits unchanged until taken
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_rx_byte))
      else $error("offered byte changed before it was taken");

   // stalled word holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_frame_kind)
         && $stable(rsp_axis_x) && $stable(rsp_axis_y) && $stable(rsp_axis_z))
      else $error("stalled result changed");

   a_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_frame_kind <= KIND_ANGLE)
      else $error("frame kind out of range");

   // acceleration and rate scale by sixteen, so low bits stay clear
   a_scale: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_frame_kind == KIND_ACCEL || rsp_frame_kind == KIND_GYRO)
         |-> rsp_axis_x[3:0] == 4'd0 && rsp_axis_y[3:0] == 4'd0
            && rsp_axis_z[3:0] == 4'd0)
      else $error("axis not a multiple of the scale");

endmodule

bind imu_frame_sync_decoder ifsd_checker u_ifsd_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .req_rx_byte    (req_rx_byte),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_frame_kind (rsp_frame_kind),
   .rsp_axis_x     (rsp_axis_x),
   .rsp_axis_y     (rsp_axis_y),
   .rsp_axis_z     (rsp_axis_z)
);
